FILE: hw/rtl/fbfla_pkg.sv
package fbfla_pkg;

    localparam int NUM_BLOCKS_DEF = 256;
    localparam int WORD_BYTES     = 8;

    localparam int CNT_W    = 9;
    localparam int BCNT_W   = 9;
    localparam int BBYTES_W = 13;
    localparam int STRIDE_W = 14;
    localparam int OFF_W    = 20;
    localparam int IDX_IN_W = 8;
    localparam int S_DATA_W = 16;
    localparam int M_DATA_W = 40;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 13;

    localparam logic [BCNT_W-1:0]   BLOCK_COUNT_RST = 9'd256;
    localparam logic [BBYTES_W-1:0] BLOCK_BYTES_RST = 13'd8;
    localparam logic [CNT_W-1:0]    COUNT_MAX       = 9'd511;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_COUNT = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BYTES = 1'b1;

    typedef enum logic [1:0] {
        OP_INIT  = 2'd0,
        OP_ALLOC = 2'd1,
        OP_FREE  = 2'd2,
        OP_COUNT = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        logic capture;
        logic exec;
        logic init_start;
        logic init_step;
        logic init_load;
    } cmd_t;

    typedef struct packed {
        op_t  op;
        logic eff_zero;
        logic init_last;
        logic slot_free;
    } stat_t;

endpackage

FILE: hw/rtl/fbfla_ctrl.sv
module fbfla_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_tvalid,
    output logic               s_tready,
    input  fbfla_pkg::stat_t   stat,
    output fbfla_pkg::cmd_t    cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_INIT,
        S_RESP
    } state_t;

    state_t state_reg, state_next;
    logic   s_tready_reg;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready_reg) begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC: begin
                if (stat.op == fbfla_pkg::OP_INIT) begin
                    cmd.init_start = 1'b1;
                    state_next     = stat.eff_zero ? S_RESP : S_INIT;
                end else if (stat.slot_free) begin
                    cmd.exec   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_INIT: begin
                cmd.init_step = 1'b1;
                if (stat.init_last) begin
                    state_next = S_RESP;
                end
            end
            S_RESP: begin
                if (stat.slot_free) begin
                    cmd.init_load = 1'b1;
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            s_tready_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            s_tready_reg <= (state_next == S_IDLE);
        end
    end

    assign s_tready = s_tready_reg;

endmodule

FILE: hw/rtl/fbfla_dpath.sv
module fbfla_dpath #(
    parameter int NUM_BLOCKS = fbfla_pkg::NUM_BLOCKS_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]     cfg_wdata,
    input  logic [fbfla_pkg::S_DATA_W-1:0]       s_tdata,
    input  fbfla_pkg::cmd_t                      cmd,
    output fbfla_pkg::stat_t                     stat,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [fbfla_pkg::M_DATA_W-1:0]       m_tdata
);

    localparam int IDX_W  = $clog2(NUM_BLOCKS);
    localparam int PTR_W  = $clog2(NUM_BLOCKS + 1);
    localparam int PROD_W = IDX_W + fbfla_pkg::STRIDE_W;
    localparam int CNT_W  = fbfla_pkg::CNT_W;
    localparam int OFF_W  = fbfla_pkg::OFF_W;
    localparam int STR_W  = fbfla_pkg::STRIDE_W;
    localparam logic [PTR_W-1:0] NULL_PTR = PTR_W'(NUM_BLOCKS);

    logic [PTR_W-1:0] link_mem [NUM_BLOCKS];

    logic [fbfla_pkg::BCNT_W-1:0]   block_count_reg;
    logic [fbfla_pkg::BBYTES_W-1:0] block_bytes_reg;

    fbfla_pkg::op_t                 op_reg;
    logic [fbfla_pkg::IDX_IN_W-1:0] idx_reg;
    logic [PTR_W-1:0]               head_reg, head_next;
    logic [CNT_W-1:0]               count_reg, count_next;
    logic [IDX_W-1:0]               init_ptr_reg, init_ptr_next;
    logic [PTR_W-1:0]               rd_data_reg;
    logic [PROD_W-1:0]              prod_reg;

    logic                           out_valid_reg;
    fbfla_pkg::status_t             out_status_reg;
    logic [fbfla_pkg::IDX_IN_W-1:0] out_granted_reg;
    logic [OFF_W-1:0]               out_offset_reg;
    logic [CNT_W-1:0]               out_count_reg;

    logic [CNT_W-1:0]               eff_blocks;
    logic [STR_W-1:0]               stride;
    logic                           head_null;
    logic [IDX_W-1:0]               head_idx;
    logic                           in_range;
    logic                           init_last;
    logic [PTR_W-1:0]               pop_link;
    logic                           slot_free;
    logic                           load_out;
    logic                           mem_we;
    logic [IDX_W-1:0]               mem_waddr;
    logic [PTR_W-1:0]               mem_wdata;
    fbfla_pkg::status_t             res_status;
    logic [fbfla_pkg::IDX_IN_W-1:0] res_granted;
    logic [OFF_W-1:0]               res_offset;

    always_comb begin
        if (int'(block_count_reg) > NUM_BLOCKS) begin
            eff_blocks = CNT_W'(NUM_BLOCKS);
        end else begin
            eff_blocks = block_count_reg;
        end
    end

    // round block size up to a whole word
    assign stride = (STR_W'(block_bytes_reg) + STR_W'(fbfla_pkg::WORD_BYTES - 1))
                    & ~STR_W'(fbfla_pkg::WORD_BYTES - 1);

    assign head_null = (head_reg >= NULL_PTR);
    assign head_idx  = head_reg[IDX_W-1:0];
    assign in_range  = (int'(idx_reg) < int'(eff_blocks));
    assign init_last = ((int'(init_ptr_reg) + 1) == int'(eff_blocks));
    assign pop_link  = (rd_data_reg > NULL_PTR) ? NULL_PTR : rd_data_reg;
    assign slot_free = !out_valid_reg || m_tready;
    assign load_out  = cmd.exec || cmd.init_load;

    assign stat.op        = op_reg;
    assign stat.eff_zero  = (eff_blocks == '0);
    assign stat.init_last = init_last;
    assign stat.slot_free = slot_free;

    always_comb begin
        head_next     = head_reg;
        count_next    = count_reg;
        init_ptr_next = init_ptr_reg;
        res_status    = fbfla_pkg::ST_OK;
        res_granted   = '0;
        res_offset    = '0;
        mem_we        = 1'b0;
        mem_waddr     = init_ptr_reg;
        mem_wdata     = init_last ? NULL_PTR : (PTR_W'(init_ptr_reg) + PTR_W'(1));

        if (cmd.init_start) begin
            init_ptr_next = '0;
            if (eff_blocks == '0) begin
                head_next  = NULL_PTR;
                count_next = '0;
            end
        end

        if (cmd.init_step) begin
            mem_we        = 1'b1;
            init_ptr_next = init_ptr_reg + IDX_W'(1);
            if (init_last) begin
                head_next  = '0;
                count_next = eff_blocks;
            end
        end

        if (cmd.exec) begin
            unique case (op_reg)
                fbfla_pkg::OP_ALLOC: begin
                    if (head_null) begin
                        res_status = fbfla_pkg::ST_EMPTY;
                    end else begin
                        res_granted = fbfla_pkg::IDX_IN_W'(head_reg);
                        res_offset  = OFF_W'(fbfla_pkg::WORD_BYTES) + OFF_W'(prod_reg);
                        head_next   = pop_link;
                        if (count_reg != '0) begin
                            count_next = count_reg - CNT_W'(1);
                        end
                    end
                end
                fbfla_pkg::OP_FREE: begin
                    if (!in_range) begin
                        res_status = fbfla_pkg::ST_RANGE;
                    end else begin
                        mem_we    = 1'b1;
                        mem_waddr = IDX_W'(idx_reg);
                        mem_wdata = head_reg;
                        head_next = PTR_W'(idx_reg);
                        if (count_reg != fbfla_pkg::COUNT_MAX) begin
                            count_next = count_reg + CNT_W'(1);
                        end
                    end
                end
                fbfla_pkg::OP_INIT: begin
                end
                fbfla_pkg::OP_COUNT: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            link_mem[mem_waddr] <= mem_wdata;
        end
        if (cmd.capture && !head_null) begin
            rd_data_reg <= link_mem[head_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            op_reg   <= fbfla_pkg::op_t'(s_tdata[1:0]);
            idx_reg  <= s_tdata[9:2];
            prod_reg <= PROD_W'(head_idx) * PROD_W'(stride);
        end
        init_ptr_reg <= init_ptr_next;
        if (load_out) begin
            out_status_reg  <= res_status;
            out_granted_reg <= res_granted;
            out_offset_reg  <= res_offset;
            out_count_reg   <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            block_count_reg <= fbfla_pkg::BLOCK_COUNT_RST;
            block_bytes_reg <= fbfla_pkg::BLOCK_BYTES_RST;
            head_reg        <= NULL_PTR;
            count_reg       <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    fbfla_pkg::CFG_BLOCK_COUNT: block_count_reg <= cfg_wdata[8:0];
                    fbfla_pkg::CFG_BLOCK_BYTES: block_bytes_reg <= cfg_wdata;
                    default: ;
                endcase
            end
            head_reg  <= head_next;
            count_reg <= count_next;
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_count_reg, out_offset_reg, out_granted_reg, out_status_reg};

endmodule

FILE: hw/rtl/fixed_block_free_list_allocator.sv
// Fixed-size block pool manager with a last-in, first-out free list.
// Input beats on s_*: tdata carries an operation (init, allocate, free,
// count) and the block index for a free. Every input beat gives exactly one
// result beat on m_*: status, granted index, byte offset and free count.
// Block count and block size are set through cfg_we/cfg_index/cfg_wdata;
// the user must write them only while idle; the block does not enforce it.
// Allocate, free and count capture the beat and read the link memory at the
// list head, then update head, counter and link memory and load the output
// register. Init walks the link memory writing one entry per cycle, up to the
// block count capped at NUM_BLOCKS.
// m_tvalid rises once the output register is free and takes the result: after
// the update for allocate, free and count, after the last link write for init.
// The output register lets the block take the next beat while a result
// waits; a stalled receiver holds the result and the next operation waits
// for the output register to free before it completes.
// A synchronous reset empties the free list, clears the free counter and
// restores the block count to 256 and the block size to 8 bytes; the link
// memory content is not cleared, the list stays empty until an init or a free.
module fixed_block_free_list_allocator #(
    parameter int NUM_BLOCKS = fbfla_pkg::NUM_BLOCKS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation[1:0], block_index[9:2], zero pad
    input  logic [fbfla_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // status[1:0], granted_index[9:2], byte_offset[29:10], free_count[38:30], zero pad
    output logic [fbfla_pkg::M_DATA_W-1:0]    m_tdata
);

    fbfla_pkg::cmd_t  cmd;
    fbfla_pkg::stat_t stat;

    fbfla_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    fbfla_dpath #(
        .NUM_BLOCKS (NUM_BLOCKS)
    ) u_dpath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tdata   (s_tdata),
        .cmd       (cmd),
        .stat      (stat),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: hw/rtl/fbfla_chk.sv
module fbfla_chk (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              cfg_we,
    input logic [fbfla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input logic [fbfla_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input logic                              s_tvalid,
    input logic                              s_tready,
    input logic [fbfla_pkg::S_DATA_W-1:0]    s_tdata,
    input logic                              m_tvalid,
    input logic                              m_tready,
    input logic [fbfla_pkg::M_DATA_W-1:0]    m_tdata
);

    // result beat holds while stalled
    a_m_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat dropped or changed under stall");

    // one beat in flight: no accept in the cycle after an accept
    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while previous beat still in work");

    // status code is one of the defined ones
    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("undefined status code");

    // failed operations grant nothing
    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tdata[1:0] != fbfla_pkg::ST_OK) |-> m_tdata[29:2] == '0)
        else $error("failed operation carries a grant or offset");

endmodule

bind fixed_block_free_list_allocator fbfla_chk u_fbfla_chk (.*);
